@@ hw/rtl/stp_pkg.sv @@
// Shared types, field widths, opcodes and register codes of the Sutherland transport unit.
// Depends on nothing; every other file of the block depends on it.
package stp_pkg;

  // Field widths of the point and of the registers.
  localparam int OP_W       = 3;
  localparam int T_W        = 24;
  localparam int G_W        = 32;
  localparam int CP_W       = 24;
  localparam int MU0_W      = 40;
  localparam int PR_W       = 20;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 40;

  // Internal datapath widths.
  localparam int TSUM_W  = T_W + 1;
  localparam int T3S_W   = T_W + 2;
  localparam int TSQ_W   = 2 * TSUM_W;
  localparam int A_W     = 44;
  localparam int BASE_W  = 112;
  localparam int FDEN_W  = 24;
  localparam int FIN_W   = BASE_W + 2 * G_W;
  localparam int FRAC_SH = 32;
  localparam int DMU_SH  = 9;
  localparam int DIGIT_W = 8;

  // Opcodes.
  localparam logic [OP_W-1:0] OP_MU     = 3'd0;
  localparam logic [OP_W-1:0] OP_DMU_DX = 3'd1;
  localparam logic [OP_W-1:0] OP_DMU_DT = 3'd2;
  localparam logic [OP_W-1:0] OP_K      = 3'd3;
  localparam logic [OP_W-1:0] OP_DK_DX  = 3'd4;
  localparam logic [OP_W-1:0] OP_DK_DT  = 3'd5;

  // Register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_MU0 = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_T0  = 8'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_S   = 8'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PR  = 8'd3;

  // Register reset values.
  localparam logic [MU0_W-1:0] MU0_RST = 40'd18867700;
  localparam logic [T_W-1:0]   T0_RST  = 24'd279706;
  localparam logic [T_W-1:0]   S_RST   = 24'd113050;
  localparam logic [PR_W-1:0]  PR_RST  = 20'd47186;

  // Fixed scale factors of the final step.
  localparam logic [FDEN_W-1:0] GRAD_SCALE = 24'd4096;
  localparam logic [G_W-1:0]    CP_SCALE   = 32'd256;

  typedef struct packed {
    logic [OP_W-1:0]        op;
    logic [T_W-1:0]         temperature;
    logic signed [G_W-1:0]  temperature_gradient;
    logic [CP_W-1:0]        specific_heat;
    logic                   last_point;
  } point_t;

  // Everything an item carries down the pipeline besides the unit operands.
  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [T_W-1:0]    t;
    logic [G_W-1:0]    gmag;
    logic              gneg;
    logic [CP_W-1:0]   cp;
    logic              last;
    logic [TSUM_W-1:0] tsum;
    logic [T3S_W-1:0]  t3s;
    logic [TSQ_W-1:0]  tsq;
    logic [A_W-1:0]    a;
    logic [BASE_W-1:0] dmu;
    logic [FDEN_W-1:0] fden;
    logic              fneg;
    logic              fovf;
  } item_t;

endpackage

@@ hw/rtl/stp_if.sv @@
// Channel interfaces of the Sutherland transport unit: points in, results out, register writes.
// Depends on stp_pkg for field widths.
interface stp_point_if;
  logic                          valid;
  logic                          ready;
  logic [stp_pkg::OP_W-1:0]      op;
  logic [stp_pkg::T_W-1:0]       temperature;
  logic signed [stp_pkg::G_W-1:0] temperature_gradient;
  logic [stp_pkg::CP_W-1:0]      specific_heat;
  logic                          last_point;
  modport source (output valid, op, temperature, temperature_gradient, specific_heat,
                  last_point, input ready);
  modport sink (input valid, op, temperature, temperature_gradient, specific_heat,
                last_point, output ready);
endinterface

interface stp_result_if #(
  parameter int RESULT_WIDTH = 48
);
  logic                           valid;
  logic                           ready;
  logic signed [RESULT_WIDTH-1:0] value;
  logic                           overflow;
  logic                           last;
  modport source (output valid, value, overflow, last, input ready);
  modport sink (input valid, value, overflow, last, output ready);
endinterface

interface stp_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [stp_pkg::CFG_IDX_W-1:0]     index;
  logic [stp_pkg::CFG_DATA_W-1:0]    data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

@@ hw/rtl/stp_front.sv @@
// Entry stages: captures a point and forms T+S, T+3S, |dT/dx| and (T+S)^2.
// Depends on stp_pkg.
module stp_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                adv,
  input  logic                in_valid,
  input  stp_pkg::point_t     pt,
  input  logic [stp_pkg::T_W-1:0] s,
  output logic                out_valid,
  output stp_pkg::item_t      out_item
);
  import stp_pkg::*;

  logic              v1, v2;
  item_t             it1, it2;
  item_t             it1_next;
  item_t             it2_next;
  logic [TSUM_W-1:0] tsum_raw;
  logic [G_W-1:0]    graw;

  // First stage: sums and gradient magnitude. A zero T+S counts as one LSB.
  always_comb begin
    graw = $unsigned(pt.temperature_gradient);
    tsum_raw = TSUM_W'(pt.temperature) + TSUM_W'(s);
    it1_next = '0;
    it1_next.op = pt.op;
    it1_next.t = pt.temperature;
    it1_next.gneg = graw[G_W-1];
    it1_next.gmag = graw[G_W-1] ? (~graw + 1'b1) : graw;
    it1_next.cp = pt.specific_heat;
    it1_next.last = pt.last_point;
    it1_next.tsum = (tsum_raw == '0) ? TSUM_W'(1) : tsum_raw;
    it1_next.t3s = T3S_W'(pt.temperature) + T3S_W'(s) + T3S_W'({s, 1'b0});
  end

  // Second stage: square of the nonzero T+S.
  always_comb begin
    it2_next = it1;
    it2_next.tsq = TSQ_W'(it1.tsum) * TSQ_W'(it1.tsum);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else if (adv) begin
      v1 <= in_valid;
      v2 <= v1;
    end
    if (adv) begin
      it1 <= it1_next;
      it2 <= it2_next;
    end
  end

  assign out_valid = v2;
  assign out_item = it2;

endmodule

@@ hw/rtl/stp_mul_pipe.sv @@
// Pipelined multiplier: one 8-bit digit of the second operand per stage, item travels alongside.
// Depends on stp_pkg.
module stp_mul_pipe #(
  parameter int WA = 8,
  parameter int WB = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             adv,
  input  logic             in_valid,
  input  stp_pkg::item_t   in_item,
  input  logic [WA-1:0]    a,
  input  logic [WB-1:0]    b,
  output logic             out_valid,
  output stp_pkg::item_t   out_item,
  output logic [WA+WB-1:0] prod
);
  import stp_pkg::*;

  localparam int NS = (WB + DIGIT_W - 1) / DIGIT_W;
  localparam int BP = NS * DIGIT_W;
  localparam int PW = WA + WB;

  logic          vld [NS];
  item_t         itm [NS];
  logic [WA-1:0] av  [NS];
  logic [BP-1:0] bv  [NS];
  logic [PW-1:0] acc [NS];

  for (genvar s = 0; s < NS; s++) begin : g_stage
    logic                  pv;
    item_t                 pi;
    logic [WA-1:0]         pa;
    logic [BP-1:0]         pb;
    logic [PW-1:0]         pacc;
    logic [WA+DIGIT_W-1:0] pp;

    if (s == 0) begin : g_head
      assign pv = in_valid;
      assign pi = in_item;
      assign pa = a;
      assign pb = BP'(b);
      assign pacc = '0;
    end else begin : g_body
      assign pv = vld[s-1];
      assign pi = itm[s-1];
      assign pa = av[s-1];
      assign pb = bv[s-1];
      assign pacc = acc[s-1];
    end

    // Partial product of this digit, added at its weight.
    assign pp = pa * pb[s*DIGIT_W +: DIGIT_W];

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s] <= 1'b0;
      end else if (adv) begin
        vld[s] <= pv;
      end
      if (adv) begin
        itm[s] <= pi;
        av[s] <= pa;
        bv[s] <= pb;
        acc[s] <= pacc + (PW'(pp) << (s * DIGIT_W));
      end
    end
  end

  assign out_valid = vld[NS-1];
  assign out_item = itm[NS-1];
  assign prod = acc[NS-1];

endmodule

@@ hw/rtl/stp_div_pipe.sv @@
// Pipelined restoring divider: one quotient bit per stage, divisor carried with the item.
// Depends on stp_pkg. A nonzero starting remainder below the divisor continues a longer division.
module stp_div_pipe #(
  parameter int NW = 8,
  parameter int DW = 8
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           adv,
  input  logic           in_valid,
  input  stp_pkg::item_t in_item,
  input  logic [NW-1:0]  num,
  input  logic [DW-1:0]  den,
  input  logic [DW-1:0]  rem0,
  output logic           out_valid,
  output stp_pkg::item_t out_item,
  output logic [NW-1:0]  quo
);
  import stp_pkg::*;

  logic          vld [NW];
  item_t         itm [NW];
  logic [NW-1:0] xv  [NW];
  logic [DW-1:0] rv  [NW];
  logic [DW-1:0] dv  [NW];

  for (genvar s = 0; s < NW; s++) begin : g_stage
    logic          pv;
    item_t         pi;
    logic [NW-1:0] px;
    logic [DW-1:0] pr;
    logic [DW-1:0] pd;
    logic [DW:0]   tr;
    logic [DW:0]   rn;
    logic          ge;

    if (s == 0) begin : g_head
      assign pv = in_valid;
      assign pi = in_item;
      assign px = num;
      assign pr = rem0;
      assign pd = den;
    end else begin : g_body
      assign pv = vld[s-1];
      assign pi = itm[s-1];
      assign px = xv[s-1];
      assign pr = rv[s-1];
      assign pd = dv[s-1];
    end

    // Shift in the next dividend bit and subtract the divisor where it fits.
    assign tr = {pr, px[NW-1]};
    assign ge = (tr >= {1'b0, pd});
    assign rn = ge ? (tr - {1'b0, pd}) : tr;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s] <= 1'b0;
      end else if (adv) begin
        vld[s] <= pv;
      end
      if (adv) begin
        itm[s] <= pi;
        xv[s] <= {px[NW-2:0], ge};
        rv[s] <= rn[DW-1:0];
        dv[s] <= pd;
      end
    end
  end

  assign out_valid = vld[NW-1];
  assign out_item = itm[NW-1];
  assign quo = xv[NW-1];

endmodule

@@ hw/rtl/stp_sqrt_pipe.sv @@
// Pipelined digit-by-digit integer square root: one root bit per stage.
// Depends on stp_pkg.
module stp_sqrt_pipe #(
  parameter int NW = 8
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            adv,
  input  logic            in_valid,
  input  stp_pkg::item_t  in_item,
  input  logic [NW-1:0]   x,
  output logic            out_valid,
  output stp_pkg::item_t  out_item,
  output logic [NW/2-1:0] root
);
  import stp_pkg::*;

  localparam int RW = NW / 2;

  logic          vld [RW];
  item_t         itm [RW];
  logic [NW-1:0] xv  [RW];
  logic [RW-1:0] qv  [RW];
  logic [RW+1:0] mv  [RW];

  for (genvar s = 0; s < RW; s++) begin : g_stage
    logic          pv;
    item_t         pi;
    logic [NW-1:0] px;
    logic [RW-1:0] pq;
    logic [RW+1:0] pm;
    logic [RW+3:0] tr;
    logic [RW+3:0] trial;
    logic [RW+3:0] rn;
    logic          ge;

    if (s == 0) begin : g_head
      assign pv = in_valid;
      assign pi = in_item;
      assign px = x;
      assign pq = '0;
      assign pm = '0;
    end else begin : g_body
      assign pv = vld[s-1];
      assign pi = itm[s-1];
      assign px = xv[s-1];
      assign pq = qv[s-1];
      assign pm = mv[s-1];
    end

    // Bring down two bits and try the next root bit.
    assign tr = {pm, px[NW-1:NW-2]};
    assign trial = {2'b00, pq, 2'b01};
    assign ge = (tr >= trial);
    assign rn = ge ? (tr - trial) : tr;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s] <= 1'b0;
      end else if (adv) begin
        vld[s] <= pv;
      end
      if (adv) begin
        itm[s] <= pi;
        xv[s] <= {px[NW-3:0], 2'b00};
        qv[s] <= {pq[RW-2:0], ge};
        mv[s] <= rn[RW+1:0];
      end
    end
  end

  assign out_valid = vld[RW-1];
  assign out_item = itm[RW-1];
  assign root = qv[RW-1];

endmodule

@@ hw/rtl/sutherland_transport_property.sv @@
// Top level of the Sutherland transport unit: registers, datapath chain and output queue.
// Depends on stp_pkg, stp_if, stp_front, stp_mul_pipe, stp_div_pipe and stp_sqrt_pipe.
//
//   channel   dir  handshake     payload
//   points    in   valid/ready   op, temperature, temperature_gradient, specific_heat, last_point
//   results   out  valid/ready   value, overflow, last
//   cfg       in   valid/ready   index, data (always ready)
//
// One item enters per cycle while the output queue has room; the pipeline is mostly the
// bit-per-stage dividers and square root: 88 + 77 + 112 + 101 + RESULT_WIDTH divider stages
// and 44 root stages, plus 2 entry stages, 42 multiplier stages, one overflow precheck stage
// and the output queue.
// Reset is synchronous and active high; it empties the pipeline and loads register defaults.
// A two-entry output queue parts the sides: the whole chain holds while the queue is full,
// and points.ready is low only then.
module sutherland_transport_property #(
  parameter int RESULT_WIDTH = 48
) (
  input logic         clk,
  input logic         rst,
  stp_point_if.sink   points,
  stp_result_if.source results,
  stp_cfg_if.sink     cfg
);
  import stp_pkg::*;

  localparam int Q1_W  = T_W + 64;
  localparam int W3    = A_W + MU0_W;
  localparam int W3S   = W3 - FRAC_SH;
  localparam int W4    = W3S + TSUM_W;
  localparam int W6    = W4 + T3S_W;
  localparam int W7    = W6 + DMU_SH;
  localparam int W8    = 2 * A_W;
  localparam int W8S   = W8 - FRAC_SH;
  localparam int W9    = W8S + A_W;
  localparam int W9S   = W9 - FRAC_SH;
  localparam int W10   = W9S + MU0_W;
  localparam int W10S  = W10 - FRAC_SH;
  localparam int W11   = W10S + TSUM_W;
  localparam int W13   = BASE_W + G_W;
  localparam int HW    = FIN_W - RESULT_WIDTH;
  localparam logic [RESULT_WIDTH-1:0] SAT_MIN = {1'b1, {(RESULT_WIDTH-1){1'b0}}};
  localparam logic [RESULT_WIDTH-1:0] SAT_MAX = {1'b0, {(RESULT_WIDTH-1){1'b1}}};

  typedef struct packed {
    logic [RESULT_WIDTH-1:0] value;
    logic                    overflow;
    logic                    last;
  } res_t;

  // Configuration registers; zero divisors count as one LSB.
  logic [MU0_W-1:0]  mu0;
  logic [T_W-1:0]    t0;
  logic [T_W-1:0]    s;
  logic [PR_W-1:0]   pr;
  logic [T_W-1:0]    t0n;
  logic [PR_W-1:0]   prn;
  logic [TSUM_W-1:0] t0s;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      mu0 <= MU0_RST;
      t0 <= T0_RST;
      s <= S_RST;
      pr <= PR_RST;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        CFG_MU0: mu0 <= cfg.data[MU0_W-1:0];
        CFG_T0:  t0 <= cfg.data[T_W-1:0];
        CFG_S:   s <= cfg.data[T_W-1:0];
        CFG_PR:  pr <= cfg.data[PR_W-1:0];
        default: ;
      endcase
    end
  end

  assign t0n = (t0 == '0) ? T_W'(1) : t0;
  assign prn = (pr == '0) ? PR_W'(1) : pr;
  assign t0s = TSUM_W'(t0n) + TSUM_W'(s);

  // Global advance: the chain moves whenever the output queue has room.
  logic [1:0] cnt;
  logic [1:0] cnt_next;
  logic       adv;
  logic       push;
  logic       pop;
  res_t       ent0, ent1;
  res_t       ent0_next, ent1_next;
  res_t       fin_res;
  logic       fin_valid;

  assign adv = (cnt != 2'd2);
  assign points.ready = adv;

  point_t pt;
  always_comb begin
    pt.op = points.op;
    pt.temperature = points.temperature;
    pt.temperature_gradient = points.temperature_gradient;
    pt.specific_heat = points.specific_heat;
    pt.last_point = points.last_point;
  end

  logic  v0;
  item_t i0;
  stp_front u_front (
    .clk, .rst, .adv, .in_valid(points.valid), .pt, .s, .out_valid(v0), .out_item(i0)
  );

  // sqrt(T/T0) in Q.32: divide T*2^64 by T0, then take the root.
  logic            v1;
  item_t           i1;
  logic [Q1_W-1:0] q1;
  stp_div_pipe #(.NW(Q1_W), .DW(T_W)) u_div_ratio (
    .clk, .rst, .adv, .in_valid(v0), .in_item(i0), .num({i0.t, 64'd0}), .den(t0n),
    .rem0('0), .out_valid(v1), .out_item(i1), .quo(q1)
  );

  logic           v2;
  item_t          i2, i2a;
  logic [A_W-1:0] root;
  stp_sqrt_pipe #(.NW(Q1_W)) u_sqrt (
    .clk, .rst, .adv, .in_valid(v1), .in_item(i1), .x(q1),
    .out_valid(v2), .out_item(i2), .root
  );

  always_comb begin
    i2a = i2;
    i2a.a = root;
  end

  // Temperature derivative of mu: mu0*a, times (T0+S)/T0, times (T+3S)*512/(T+S)^2.
  logic          v3, v4, v5, v6, v7;
  item_t         i3, i4, i5, i6, i7, i7a;
  logic [W3-1:0] p3;
  logic [W4-1:0] p4;
  logic [W4-1:0] q5;
  logic [W6-1:0] p6;
  logic [W7-1:0] q7;

  stp_mul_pipe #(.WA(A_W), .WB(MU0_W)) u_mul_mu0a (
    .clk, .rst, .adv, .in_valid(v2), .in_item(i2a), .a(i2a.a), .b(mu0),
    .out_valid(v3), .out_item(i3), .prod(p3)
  );
  stp_mul_pipe #(.WA(W3S), .WB(TSUM_W)) u_mul_dref (
    .clk, .rst, .adv, .in_valid(v3), .in_item(i3), .a(p3[W3-1:FRAC_SH]), .b(t0s),
    .out_valid(v4), .out_item(i4), .prod(p4)
  );
  stp_div_pipe #(.NW(W4), .DW(T_W)) u_div_t0 (
    .clk, .rst, .adv, .in_valid(v4), .in_item(i4), .num(p4), .den(t0n), .rem0('0),
    .out_valid(v5), .out_item(i5), .quo(q5)
  );
  stp_mul_pipe #(.WA(W4), .WB(T3S_W)) u_mul_t3s (
    .clk, .rst, .adv, .in_valid(v5), .in_item(i5), .a(q5), .b(i5.t3s),
    .out_valid(v6), .out_item(i6), .prod(p6)
  );
  stp_div_pipe #(.NW(W7), .DW(TSQ_W)) u_div_tsq (
    .clk, .rst, .adv, .in_valid(v6), .in_item(i6), .num({p6, {DMU_SH{1'b0}}}),
    .den(i6.tsq), .rem0('0), .out_valid(v7), .out_item(i7), .quo(q7)
  );

  always_comb begin
    i7a = i7;
    i7a.dmu = BASE_W'(q7);
  end

  // Viscosity: a^3 in Q.32 times mu0, times (T0+S)/(T+S).
  logic           v8, v9, v10, v11, v12;
  item_t          i8, i9, i10, i11, i12;
  logic [W8-1:0]  p8;
  logic [W9-1:0]  p9;
  logic [W10-1:0] p10;
  logic [W11-1:0] p11;
  logic [W11-1:0] q12;

  stp_mul_pipe #(.WA(A_W), .WB(A_W)) u_mul_aa (
    .clk, .rst, .adv, .in_valid(v7), .in_item(i7a), .a(i7a.a), .b(i7a.a),
    .out_valid(v8), .out_item(i8), .prod(p8)
  );
  stp_mul_pipe #(.WA(W8S), .WB(A_W)) u_mul_aaa (
    .clk, .rst, .adv, .in_valid(v8), .in_item(i8), .a(p8[W8-1:FRAC_SH]), .b(i8.a),
    .out_valid(v9), .out_item(i9), .prod(p9)
  );
  stp_mul_pipe #(.WA(W9S), .WB(MU0_W)) u_mul_mu0 (
    .clk, .rst, .adv, .in_valid(v9), .in_item(i9), .a(p9[W9-1:FRAC_SH]), .b(mu0),
    .out_valid(v10), .out_item(i10), .prod(p10)
  );
  stp_mul_pipe #(.WA(W10S), .WB(TSUM_W)) u_mul_ref (
    .clk, .rst, .adv, .in_valid(v10), .in_item(i10), .a(p10[W10-1:FRAC_SH]), .b(t0s),
    .out_valid(v11), .out_item(i11), .prod(p11)
  );
  stp_div_pipe #(.NW(W11), .DW(TSUM_W)) u_div_tsum (
    .clk, .rst, .adv, .in_valid(v11), .in_item(i11), .num(p11), .den(i11.tsum),
    .rem0('0), .out_valid(v12), .out_item(i12), .quo(q12)
  );

  // Opcode decode: base value, first factor, final divisor and sign.
  item_t             i12a;
  logic [BASE_W-1:0] base;
  logic [G_W-1:0]    m1;

  always_comb begin
    i12a = i12;
    i12a.fden = FDEN_W'(1);
    i12a.fneg = 1'b0;
    i12a.fovf = 1'b0;
    base = '0;
    m1 = G_W'(1);
    unique case (i12.op)
      OP_MU: begin
        base = BASE_W'(q12);
      end
      OP_DMU_DX: begin
        base = i12.dmu;
        m1 = i12.gmag;
        i12a.fden = GRAD_SCALE;
        i12a.fneg = i12.gneg;
      end
      OP_DMU_DT: begin
        base = i12.dmu;
      end
      OP_K: begin
        base = BASE_W'(q12);
        m1 = G_W'(i12.cp);
        i12a.fden = FDEN_W'(prn);
      end
      OP_DK_DX: begin
        base = i12.dmu;
        m1 = G_W'(i12.cp);
        i12a.fden = {prn, 4'b0000};
        i12a.fneg = i12.gneg;
      end
      OP_DK_DT: begin
        base = i12.dmu;
        m1 = G_W'(i12.cp);
        i12a.fden = FDEN_W'(prn);
      end
      default: ;
    endcase
  end

  logic             v13, v14;
  item_t            i13, i14;
  logic [W13-1:0]   p13;
  logic [FIN_W-1:0] p14;
  logic [G_W-1:0]   m2;

  stp_mul_pipe #(.WA(BASE_W), .WB(G_W)) u_mul_m1 (
    .clk, .rst, .adv, .in_valid(v12), .in_item(i12a), .a(base), .b(m1),
    .out_valid(v13), .out_item(i13), .prod(p13)
  );

  // Second factor: Cp scale for conductivity and dk/dT, gradient for dk/dx, one otherwise.
  always_comb begin
    unique case (i13.op) inside
      OP_K, OP_DK_DT: m2 = CP_SCALE;
      OP_DK_DX:       m2 = i13.gmag;
      default:        m2 = G_W'(1);
    endcase
  end

  stp_mul_pipe #(.WA(W13), .WB(G_W)) u_mul_m2 (
    .clk, .rst, .adv, .in_valid(v13), .in_item(i13), .a(p13), .b(m2),
    .out_valid(v14), .out_item(i14), .prod(p14)
  );

  // Overflow precheck: a quotient of RESULT_WIDTH bits or more saturates.
  logic                    vp;
  item_t                   ip;
  item_t                   ip_next;
  logic [RESULT_WIDTH-1:0] lowp;
  logic [FDEN_W-1:0]       remp;
  logic [HW-1:0]           hi;
  logic                    hi_ovf;

  assign hi = p14[FIN_W-1:RESULT_WIDTH];
  assign hi_ovf = (hi >= HW'(i14.fden));

  always_comb begin
    ip_next = i14;
    ip_next.fovf = hi_ovf;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vp <= 1'b0;
    end else if (adv) begin
      vp <= v14;
    end
    if (adv) begin
      ip <= ip_next;
      lowp <= p14[RESULT_WIDTH-1:0];
      remp <= hi_ovf ? '0 : hi[FDEN_W-1:0];
    end
  end

  item_t                   i15;
  logic [RESULT_WIDTH-1:0] q15;
  stp_div_pipe #(.NW(RESULT_WIDTH), .DW(FDEN_W)) u_div_final (
    .clk, .rst, .adv, .in_valid(vp), .in_item(ip), .num(lowp), .den(ip.fden),
    .rem0(remp), .out_valid(fin_valid), .out_item(i15), .quo(q15)
  );

  // Sign and saturation.
  logic fin_ovf;
  always_comb begin
    if (i15.fneg) begin
      fin_ovf = i15.fovf || (q15[RESULT_WIDTH-1] && (q15[RESULT_WIDTH-2:0] != '0));
      fin_res.value = fin_ovf ? SAT_MIN : (~q15 + 1'b1);
    end else begin
      fin_ovf = i15.fovf || q15[RESULT_WIDTH-1];
      fin_res.value = fin_ovf ? SAT_MAX : q15;
    end
    fin_res.overflow = fin_ovf;
    fin_res.last = i15.last;
  end

  // Two-entry output queue.
  logic [1:0] occ;
  assign pop = (cnt != 2'd0) && results.ready;
  assign push = fin_valid && adv;
  assign occ = cnt - {1'b0, pop};
  assign cnt_next = occ + {1'b0, push};

  always_comb begin
    ent0_next = ent0;
    ent1_next = ent1;
    if (pop) begin
      ent0_next = ent1;
    end
    if (push) begin
      if (occ == 2'd0) begin
        ent0_next = fin_res;
      end else begin
        ent1_next = fin_res;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
    end else begin
      cnt <= cnt_next;
    end
    ent0 <= ent0_next;
    ent1 <= ent1_next;
  end

  assign results.valid = (cnt != 2'd0);
  assign results.value = ent0.value;
  assign results.overflow = ent0.overflow;
  assign results.last = ent0.last;

  // A flagged result sits at one of the two extremes.
  a_ovf_extreme: assert property (@(posedge clk) disable iff (rst)
    results.valid && results.overflow |-> results.value == SAT_MAX || results.value == SAT_MIN)
    else $error("overflow flagged on a value that is not saturated");

  // Codes without a meaning give a clean zero.
  a_undef_zero: assert property (@(posedge clk) disable iff (rst)
    fin_valid && (i15.op > OP_DK_DT) |-> fin_res.value == '0 && !fin_ovf)
    else $error("undefined opcode did not give zero");

  // A held chain keeps its finished item.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    fin_valid && !adv |=> fin_valid && $stable(fin_res))
    else $error("finished item changed while the chain was held");

  // An unsigned result never shows a negative value.
  a_pos_sign: assert property (@(posedge clk) disable iff (rst)
    fin_valid && !i15.fneg |-> !fin_res.value[RESULT_WIDTH-1])
    else $error("positive result came out negative");

endmodule

@@ tb/sutherland_transport_property_tb.sv @@
// Testbench of the Sutherland transport unit: a directed table, then random points under
// several register settings, checked against a bit-exact predictor written here.
// Depends on stp_pkg, the stp_if interfaces and the sutherland_transport_property top.
`timescale 1ns / 1ps

module sutherland_transport_property_tb;
  import stp_pkg::*;

  localparam int RW = 48;
  localparam int LATENCY = 468 + RW;
  localparam int WATCHDOG_LIMIT = 8000;
  localparam int HOLD_CYCLES = 2500;
  localparam int RANDOM_FIRST = 700;
  localparam int RANDOM_PER_PHASE = 282;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 8'd9;
  localparam logic [OP_W-1:0] OP_SPARE_A = 3'd6;
  localparam logic [OP_W-1:0] OP_SPARE_B = 3'd7;

  typedef struct {
    logic [RW-1:0] value;
    logic          overflow;
    logic          last;
  } result_t;

  typedef struct {
    point_t  pt;
    bit      known;
    result_t res;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  stp_point_if pts ();
  stp_result_if #(.RESULT_WIDTH(RW)) res ();
  stp_cfg_if cfg ();

  sutherland_transport_property #(.RESULT_WIDTH(RW)) i_dut (
    .clk(clk), .rst(rst), .points(pts), .results(res), .cfg(cfg)
  );

  // Clock with a 12 ns period.
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Predictor copy of the registers.
  logic [MU0_W-1:0] mu0_q;
  logic [T_W-1:0]   t0_q;
  logic [T_W-1:0]   s_q;
  logic [PR_W-1:0]  pr_q;

  result_t expected_results[$];
  bit      failed = 1'b0;
  bit      calm = 1'b0;
  bit      hold_req = 1'b0;
  bit      sat_hit;

  // 128 x 64 multiply that clamps to all ones when the product leaves 128 bits.
  function automatic logic [127:0] mul_clamp(logic [127:0] x, logic [63:0] m);
    logic [191:0] p;
    p = {64'd0, x} * {128'd0, m};
    if (p[191:128] != 0) begin
      sat_hit = 1'b1;
      return '1;
    end
    return p[127:0];
  endfunction

  function automatic logic [127:0] div_floor(logic [127:0] x, logic [63:0] d);
    if (d == 0) d = 1;
    return x / {64'd0, d};
  endfunction

  function automatic logic [63:0] root_floor(logic [127:0] x);
    logic [63:0]  r;
    logic [63:0]  cand;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      cand = r | (64'd1 << b);
      if ({64'd0, cand} * {64'd0, cand} <= x) r = cand;
    end
    return r;
  endfunction

  // Transport property of one point under the current registers.
  function automatic result_t transport_of(point_t p);
    result_t      r;
    logic [63:0]  t, s, t0e, pre, tsum, gmag, a, m1, m2, dv, half, val;
    logic [127:0] mu, dmu, base, q;
    bit           gneg, neg, ovf;
    t = 64'(p.temperature);
    s = 64'(s_q);
    t0e = (t0_q != 0) ? 64'(t0_q) : 64'd1;
    pre = (pr_q != 0) ? 64'(pr_q) : 64'd1;
    tsum = (t + s != 0) ? t + s : 64'd1;
    gneg = p.temperature_gradient[G_W-1];
    gmag = gneg ? (64'h1_0000_0000 - {32'd0, p.temperature_gradient})
                : {32'd0, p.temperature_gradient};
    half = 64'd1 << (RW - 1);
    sat_hit = 1'b0;
    neg = 1'b0;
    m1 = 1;
    m2 = 1;
    dv = 1;

    a = root_floor(div_floor({40'd0, p.temperature, 64'd0}, t0e));
    mu = ({64'd0, a} * {64'd0, a}) >> 32;
    mu = mul_clamp(mu, a) >> 32;
    mu = mul_clamp(mu, 64'(mu0_q)) >> 32;
    mu = div_floor(mul_clamp(mu, t0e + s), tsum);

    dmu = ({64'd0, 24'd0, mu0_q} * {64'd0, a}) >> 32;
    dmu = div_floor(mul_clamp(dmu, t0e + s), t0e);
    dmu = mul_clamp(dmu, t + 3 * s);
    dmu = mul_clamp(dmu, 64'd512);
    dmu = div_floor(dmu, tsum * tsum);

    base = dmu;
    case (p.op)
      OP_MU:     base = mu;
      OP_DMU_DX: begin m1 = gmag; dv = 4096; neg = gneg; end
      OP_DMU_DT: ;
      OP_K:      begin base = mu; m1 = 64'(p.specific_heat); m2 = 256; dv = pre; end
      OP_DK_DX:  begin m1 = 64'(p.specific_heat); m2 = gmag; dv = pre * 16; neg = gneg; end
      OP_DK_DT:  begin m1 = 64'(p.specific_heat); m2 = 256; dv = pre; end
      default:   begin base = '0; sat_hit = 1'b0; end
    endcase
    base = mul_clamp(base, m1);
    base = mul_clamp(base, m2);
    q = div_floor(base, dv);

    ovf = 1'b0;
    if (neg) begin
      if (sat_hit || q[127:64] != 0 || q[63:0] > half) begin
        val = half;
        ovf = 1'b1;
      end else begin
        val = 64'd0 - q[63:0];
      end
    end else begin
      if (sat_hit || q[127:64] != 0 || q[63:0] > half - 1) begin
        val = half - 1;
        ovf = 1'b1;
      end else begin
        val = q[63:0];
      end
    end
    r.value = val[RW-1:0];
    r.overflow = ovf;
    r.last = p.last_point;
    return r;
  endfunction

  // Register write as the block keeps it: low bits only, unknown indexes ignored.
  function automatic void note_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
    case (idx)
      CFG_MU0: mu0_q = d[MU0_W-1:0];
      CFG_T0:  t0_q = d[T_W-1:0];
      CFG_S:   s_q = d[T_W-1:0];
      CFG_PR:  pr_q = d[PR_W-1:0];
      default: ;
    endcase
  endfunction

  task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
    @(negedge clk);
    cfg.valid = 1'b1;
    cfg.index = idx;
    cfg.data = d;
    do @(posedge clk); while (!cfg.ready);
    note_register(idx, d);
    @(negedge clk);
    cfg.valid = 1'b0;
  endtask

  // Offer one point, at times with a random idle burst before it, and record its expectation.
  task automatic send_point(point_t p, bit known, result_t r);
    @(negedge clk);
    if (!calm && $urandom_range(0, 5) == 0) begin
      pts.valid = 1'b0;
      repeat ($urandom_range(1, 11)) @(negedge clk);
    end
    pts.valid = 1'b1;
    pts.op = p.op;
    pts.temperature = p.temperature;
    pts.temperature_gradient = p.temperature_gradient;
    pts.specific_heat = p.specific_heat;
    pts.last_point = p.last_point;
    do @(posedge clk); while (!pts.ready);
    expected_results.push_back(known ? r : transport_of(p));
  endtask

  task automatic wait_drained();
    @(negedge clk);
    pts.valid = 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  function automatic point_t random_point();
    point_t p;
    int     k;
    k = $urandom_range(0, 19);
    if (k < 18)                           p.op = OP_W'($urandom_range(0, 5));
    else if ($urandom_range(0, 1) != 0)   p.op = OP_SPARE_B;
    else                                  p.op = OP_SPARE_A;
    k = $urandom_range(0, 19);
    if (k < 10)      p.temperature = T_W'($urandom_range(200 * 1024, 2000 * 1024));
    else if (k < 14) p.temperature = T_W'($urandom);
    else if (k < 17) p.temperature = T_W'($urandom_range(0, 4096));
    else             p.temperature = ($urandom_range(0, 1) != 0) ? '1 : '0;
    k = $urandom_range(0, 9);
    if (k < 6)      p.temperature_gradient = $signed($urandom);
    else if (k < 8) p.temperature_gradient = $signed(32'($urandom_range(0, 8191)) - 32'd4096);
    else begin
      case ($urandom_range(0, 3))
        0: p.temperature_gradient = 32'sh8000_0000;
        1: p.temperature_gradient = 32'sh7fff_ffff;
        2: p.temperature_gradient = '0;
        default: p.temperature_gradient = -32'sd1;
      endcase
    end
    p.specific_heat = ($urandom_range(0, 2) == 0) ? CP_W'($urandom)
                                                   : CP_W'($urandom_range(900 * 256, 1100 * 256));
    p.last_point = ($urandom_range(0, 7) == 0);
    return p;
  endfunction

  // Result side: random stall bursts, plus one long hold-off on request.
  initial begin
    int stall_left;
    stall_left = 0;
    res.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        res.ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end
      if (stall_left > 0) begin
        res.ready = 1'b0;
        stall_left--;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        res.ready = 1'b0;
        stall_left = $urandom_range(0, 10);
      end else begin
        res.ready = 1'b1;
      end
    end
  end

  // Compare each accepted result with the oldest expectation.
  always @(posedge clk) begin
    result_t e;
    if (!rst && res.valid && res.ready) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result value=%h overflow=%b last=%b", $time,
                 res.value, res.overflow, res.last);
        failed = 1'b1;
      end else begin
        e = expected_results.pop_front();
        if (res.value !== e.value) begin
          $display("%0t: value expected %h actual %h", $time, e.value, res.value);
          failed = 1'b1;
        end
        if (res.overflow !== e.overflow) begin
          $display("%0t: overflow expected %b actual %b", $time, e.overflow, res.overflow);
          failed = 1'b1;
        end
        if (res.last !== e.last) begin
          $display("%0t: last expected %b actual %b", $time, e.last, res.last);
          failed = 1'b1;
        end
      end
    end
  end

  // Watchdog on cycles in which no channel moves an item.
  always @(posedge clk) begin
    int quiet;
    if (rst || (pts.valid && pts.ready) || (res.valid && res.ready) ||
        (cfg.valid && cfg.ready)) begin
      quiet = 0;
    end else begin
      quiet++;
      if (quiet >= WATCHDOG_LIMIT) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  // Main sequence: directed table, then random phases under several settings.
  initial begin
    row_t    rows[$];
    row_t    w;
    result_t zero_res;
    point_t  p;
    int      n;

    pts.valid = 1'b0;
    pts.op = OP_MU;
    pts.temperature = '0;
    pts.temperature_gradient = '0;
    pts.specific_heat = '0;
    pts.last_point = 1'b0;
    cfg.valid = 1'b0;
    cfg.index = CFG_MU0;
    cfg.data = '0;
    mu0_q = MU0_RST;
    t0_q = T0_RST;
    s_q = S_RST;
    pr_q = PR_RST;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Zero temperature gives zero for every op; spare opcodes give zero.
    zero_res.value = '0;
    zero_res.overflow = 1'b0;
    for (int op = 0; op < 8; op++) begin
      w.pt.op = OP_W'(op);
      w.pt.temperature = '0;
      w.pt.temperature_gradient = (op % 2 != 0) ? 32'sh8000_0000 : 32'sh7fff_ffff;
      w.pt.specific_heat = '1;
      w.pt.last_point = op[0];
      w.known = 1'b1;
      w.res = zero_res;
      w.res.last = op[0];
      if (op >= 6) w.pt.temperature = '1;
      rows.push_back(w);
    end
    // Extremes of temperature, gradient and specific heat, and a plain 300 K point.
    for (int op = 0; op < 6; op++) begin
      w.known = 1'b0;
      w.pt.op = OP_W'(op);
      w.pt.temperature = '1;
      w.pt.temperature_gradient = 32'sh8000_0000;
      w.pt.specific_heat = '1;
      w.pt.last_point = 1'b1;
      rows.push_back(w);
      w.pt.temperature = T_W'(300 * 1024);
      w.pt.temperature_gradient = 32'sh7fff_ffff;
      w.pt.specific_heat = CP_W'(1005 * 256);
      w.pt.last_point = 1'b0;
      rows.push_back(w);
    end
    foreach (rows[i]) send_point(rows[i].pt, rows[i].known, rows[i].res);
    wait_drained();

    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        1: begin
          write_register(CFG_MU0, '1);
          write_register(CFG_T0, CFG_DATA_W'(1024));
          write_register(CFG_S, '0);
          write_register(CFG_PR, CFG_DATA_W'(1));
        end
        2: begin
          write_register(CFG_MU0, CFG_DATA_W'(1));
          write_register(CFG_T0, CFG_DATA_W'(24'hffffff));
          write_register(CFG_S, CFG_DATA_W'(24'hffffff));
          write_register(CFG_PR, CFG_DATA_W'(20'hfffff));
        end
        3: begin
          // Zero divisors, and data wider than the registers.
          write_register(CFG_MU0, {8'd0, $urandom});
          write_register(CFG_T0, 40'hab_cd00_0000);
          write_register(CFG_S, CFG_DATA_W'($urandom_range(0, 200 * 1024)));
          write_register(CFG_PR, 40'hff_fff0_0000);
          write_register(CFG_UNUSED, '1);
        end
        4: begin
          write_register(CFG_MU0, CFG_DATA_W'(MU0_RST));
          write_register(CFG_T0, {16'hffff, T0_RST});
          write_register(CFG_S, CFG_DATA_W'(S_RST));
          write_register(CFG_PR, CFG_DATA_W'(PR_RST));
          calm = 1'b1;
        end
        default: ;
      endcase
      // The first phase is long enough to fill the whole pipeline during the hold-off.
      n = (ph == 0) ? RANDOM_FIRST : RANDOM_PER_PHASE;
      for (int i = 0; i < n; i++) begin
        if (ph == 0 && i == 40) hold_req = 1'b1;
        p = random_point();
        send_point(p, 1'b0, zero_res);
      end
      wait_drained();
    end

    repeat (LATENCY + 50) @(posedge clk);
    if (!failed && expected_results.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
